@@ hw/rtl/shcp_pkg.sv @@
// Shared types, character constants and decode functions for the serial hex command parser.
`timescale 1ns / 1ps

package shcp_pkg;

   localparam logic [7:0] CH_EVENT = 8'h21;
   localparam logic [7:0] CH_EQUAL = 8'h3D;
   localparam logic [7:0] CH_COLON = 8'h3A;
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_LF    = 8'h0A;
   localparam logic [7:0] CASE_BIT = 8'h20;

   localparam int PAYLOAD_W = 16;
   localparam int RSP_DATA_W = 32;

   typedef enum logic [1:0] {
      PH_IDENT,
      PH_SEP,
      PH_DIGIT,
      PH_TERM
   } phase_type;

   typedef struct packed {
      logic                 hit;
      logic                 is_event;
      logic [7:0]           ident;
      logic                 sep_colon;
      logic [PAYLOAD_W-1:0] payload;
   } parse_result_type;

   typedef struct packed {
      logic       ok;
      logic [3:0] value;
   } hex_digit_type;

   function automatic logic is_ident_char(input logic [7:0] c);
      logic ok;
      ok = (c inside {[8'h41:8'h5A], [8'h61:8'h7A]}) || (c == CH_EVENT);
      return ok;
   endfunction

   function automatic hex_digit_type hex_decode(input logic [7:0] c);
      hex_digit_type d;
      logic [7:0]    up;
      d  = '0;
      up = c & ~CASE_BIT;
      if (c inside {[8'h30:8'h39]}) begin
         d.ok    = 1'b1;
         d.value = c[3:0];
      end else if (up inside {[8'h41:8'h46]}) begin
         d.ok    = 1'b1;
         d.value = 4'(up[3:0] + 4'd9);
      end
      return d;
   endfunction

endpackage

@@ hw/rtl/shcp_line_parse.sv @@
// Line recognizer: phase state, digit count, held identifier/separator and hex accumulator.
`timescale 1ns / 1ps

module shcp_line_parse import shcp_pkg::*; #(
   parameter int HEX_DIGITS = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic [7:0]       char_in,
   input  logic             step,
   output parse_result_type result
);

   localparam int CNT_W = (HEX_DIGITS > 1) ? $clog2(HEX_DIGITS) : 1;
   localparam logic [CNT_W-1:0] LAST_DIGIT = CNT_W'(HEX_DIGITS - 1);

   phase_type            phase_ff, phase_in;
   logic [CNT_W-1:0]     count_ff, count_in;
   logic [7:0]           ident_ff, ident_in;
   logic                 sep_ff, sep_in;
   logic [PAYLOAD_W-1:0] accum_ff, accum_in;
   hex_digit_type        digit;

   assign digit = hex_decode(char_in);

   // next state
   always_comb begin
      phase_in = phase_ff;
      count_in = count_ff;
      ident_in = ident_ff;
      sep_in   = sep_ff;
      accum_in = accum_ff;
      if (step) begin
         case (phase_ff)
            PH_IDENT: begin
               if (is_ident_char(char_in)) begin
                  phase_in = PH_SEP;
                  ident_in = char_in;
                  accum_in = '0;
                  count_in = '0;
               end
            end
            PH_SEP: begin
               if (char_in == CH_EQUAL || char_in == CH_COLON) begin
                  phase_in = PH_DIGIT;
                  sep_in   = (char_in == CH_COLON);
               end else begin
                  phase_in = PH_IDENT;
               end
            end
            PH_DIGIT: begin
               if (digit.ok) begin
                  accum_in = {accum_ff[PAYLOAD_W-5:0], digit.value};
                  if (count_ff == LAST_DIGIT) begin
                     phase_in = PH_TERM;
                  end else begin
                     count_in = count_ff + 1'b1;
                  end
               end else begin
                  phase_in = PH_IDENT;
               end
            end
            PH_TERM: begin
               phase_in = PH_IDENT;
            end
            default: begin
               phase_in = PH_IDENT;
            end
         endcase
      end
   end

   // outputs
   always_comb begin
      result.hit       = (phase_ff == PH_TERM) && (char_in == CH_CR || char_in == CH_LF);
      result.is_event  = (ident_ff == CH_EVENT);
      result.ident     = ident_ff;
      result.sep_colon = sep_ff;
      result.payload   = accum_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDENT;
         count_ff <= '0;
         ident_ff <= '0;
         sep_ff   <= 1'b0;
         accum_ff <= '0;
      end else begin
         phase_ff <= phase_in;
         count_ff <= count_in;
         ident_ff <= ident_in;
         sep_ff   <= sep_in;
         accum_ff <= accum_in;
      end
   end

endmodule

@@ hw/rtl/serial_hex_command_parser.sv @@
// Top level of the serial hex command parser: input register, line recognizer, result register.
// Usage:
//   req_* carries one received serial byte per transaction (req_tdata).
//   rsp_* carries one transaction per well-formed line: identifier (letter or '!'),
//   separator ('=' or ':'), HEX_DIGITS hex digits, then CR or LF.
//   rsp_tuser is 1 for an event-flag command ('!'), 0 for a message.
//   Bytes that break the line format drop it silently; no transaction results.
// Ordering: the terminator byte is first taken into the input register, then decoded
//   out of it and loaded into the result register, which drives rsp_tvalid; a full
//   result register holds the load until it is drained.
// Throughput: one byte per cycle while a completed line finds room in the result
//   register; the decode between the input register and the result register is combinational.
// Stall: while a result waits on rsp_tready, the input register still takes one
//   byte, and bytes that give no result keep flowing through the recognizer; only a
//   second completed line holds until the result register frees.
// Reset: synchronous, active high; both channels go empty and the recognizer
//   waits for an identifier.
`timescale 1ns / 1ps

module serial_hex_command_parser import shcp_pkg::*; #(
   parameter int HEX_DIGITS = 4
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [7:0]            req_tdata,   // [7:0] rx_byte
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,   // [7:0] ident, [8] sep_colon, [24:9] payload, rest 0
   output logic                  rsp_tuser    // [0] is_event
);

   logic             in_valid_ff, in_valid_in;
   logic [7:0]       in_byte_ff, in_byte_in;
   logic             out_valid_ff, out_valid_in;
   parse_result_type out_ff, out_in;
   parse_result_type result;
   logic             out_free;
   logic             step;
   logic             req_take;

   // result register can take a new line when empty or being drained
   assign out_free = !out_valid_ff || rsp_tready;
   // held byte moves into the recognizer unless it completes a line with no room
   assign step     = in_valid_ff && (!result.hit || out_free);
   assign req_tready = !in_valid_ff || step;
   assign req_take   = req_tvalid && req_tready;

   shcp_line_parse #(
      .HEX_DIGITS(HEX_DIGITS)
   ) u_parse (
      .clock  (clock),
      .reset  (reset),
      .char_in(in_byte_ff),
      .step   (step),
      .result (result)
   );

   always_comb begin
      in_valid_in = in_valid_ff;
      in_byte_in  = in_byte_ff;
      if (req_take) begin
         in_valid_in = 1'b1;
         in_byte_in  = req_tdata;
      end else if (step) begin
         in_valid_in = 1'b0;
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      out_in       = out_ff;
      if (step && result.hit) begin
         out_valid_in = 1'b1;
         out_in       = result;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      in_byte_ff <= in_byte_in;
      out_ff     <= out_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tuser  = out_ff.is_event;
   assign rsp_tdata  = {7'd0, out_ff.payload, out_ff.sep_colon, out_ff.ident};

endmodule
